// ===== rtl/mjs_pkg.sv =====
`timescale 1ns / 1ps

package mjs_pkg;

	// Widths fixed by the word formats.
	localparam int STEP_BITS      = 20;
	localparam int DUR_BITS       = 32;
	localparam int POS_BITS       = 32;
	localparam int TIME_BITS      = 36;
	localparam int IDX_PORT_BITS  = 16;
	localparam int INDEX_BITS_DEF = 16;
	localparam int INDEX_BITS_MAX = 24;

	// Step register reset value in microseconds.
	localparam logic [STEP_BITS-1:0] STEP_RESET = 20'd1000;

	// Normalised time uses 30 fraction bits.
	localparam int FRAC = 30;
	localparam logic [FRAC:0] ONE = 31'h4000_0000;

	// Microseconds per second and the extra fraction bits of the rate.
	localparam int US_PER_S   = 1000000;
	localparam int RATE_EXTRA = 12;
	localparam int VEL_SHIFT  = FRAC + RATE_EXTRA;

	// Input word: one segment and the sample wanted.
	typedef struct packed {
		logic signed [POS_BITS-1:0] start_x;
		logic signed [POS_BITS-1:0] start_y;
		logic signed [POS_BITS-1:0] start_z;
		logic signed [POS_BITS-1:0] end_x;
		logic signed [POS_BITS-1:0] end_y;
		logic signed [POS_BITS-1:0] end_z;
		logic [DUR_BITS-1:0]        duration_us;
		logic [IDX_PORT_BITS-1:0]   sample_index;
	} mjs_in_t;

	// Output word: one sample of the blend.
	typedef struct packed {
		logic signed [POS_BITS-1:0] pos_x;
		logic signed [POS_BITS-1:0] pos_y;
		logic signed [POS_BITS-1:0] pos_z;
		logic signed [POS_BITS-1:0] vel_x;
		logic signed [POS_BITS-1:0] vel_y;
		logic signed [POS_BITS-1:0] vel_z;
		logic [TIME_BITS-1:0]       time_us;
		logic                       last_sample;
		logic                       beyond_end;
	} mjs_out_t;

	// Per-word values that travel alongside the arithmetic.
	typedef struct packed {
		logic [2:0][POS_BITS-1:0] st;
		logic [2:0][POS_BITS-1:0] mag;
		logic [2:0]               neg;
		logic [DUR_BITS-1:0]      dur;
		logic [TIME_BITS-1:0]     tm;
		logic                     last;
		logic                     beyond;
		logic                     ge;
	} mjs_side_t;

endpackage

// ===== rtl/mjs_stream_if.sv =====
`timescale 1ns / 1ps

// Valid/ready channel carrying one word of the given payload type.
interface mjs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/min_jerk_segment_sampler_unit.sv =====
`timescale 1ns / 1ps

// Minimum-jerk segment sampler.
// samp_in takes one word per segment sample: start and end points in three axes
// (Q16.16 metres), the segment duration in microseconds and the sample index.
// samp_out gives the blended position, the velocity (Q16.16 m/s, saturated),
// the sample time and the last-sample and beyond-end flags, one word per input.
// cfg_we/cfg_wdata write the sampling step in microseconds; write it only while
// the pipeline is empty.
// Throughput is one word per cycle while the receiver does not stall. From
// acceptance to samp_out a word passes two set-up stages, 15 stages of the
// time-ratio divider (two quotient bits each), five polynomial stages, 32 stages
// of the rate divider (two quotient bits each) and two multiply stages.
// The whole pipeline advances together; when the receiver stalls with a word
// waiting at the output, every stage holds and samp_in.ready falls, so nothing
// is lost or repeated. Empty stages keep advancing while the output is free.
// Reset clears all valid bits and sets the step back to 1000 microseconds.
module min_jerk_segment_sampler_unit #(
	parameter int INDEX_BITS = mjs_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mjs_pkg::STEP_BITS-1:0] cfg_wdata,
	mjs_stream_if.sink                    samp_in,
	mjs_stream_if.source                  samp_out
);
	import mjs_pkg::*;

	localparam int T_BITS    = INDEX_BITS + STEP_BITS;
	localparam int DSTEP     = 2;
	localparam int D1_STAGES = FRAC / DSTEP;
	localparam int NUM_BITS  = 64;
	localparam int D2_STAGES = NUM_BITS / DSTEP;
	localparam int D1_BASE   = 1;
	localparam int D1_END    = D1_BASE + D1_STAGES;
	localparam int P1        = D1_END + 1;
	localparam int P2        = P1 + 1;
	localparam int P3        = P2 + 1;
	localparam int P4        = P3 + 1;
	localparam int D2_BASE   = P4 + 1;
	localparam int D2_END    = D2_BASE + D2_STAGES;
	localparam int M1        = D2_END + 1;
	localparam int M2        = M1 + 1;
	localparam int N_STAGES  = M2 + 1;

	localparam logic [34:0] POLY_C0 = 35'(ONE) * 35'd10;

	// One restoring division step: returns the new remainder and the quotient bit.
	function automatic logic [DUR_BITS:0] div_step(input logic [DUR_BITS-1:0] rem,
			input logic bit_in, input logic [DUR_BITS-1:0] dv);
		logic [DUR_BITS:0] r2;
		logic [DUR_BITS:0] res;
		r2 = {rem, bit_in};
		if (r2 >= {1'b0, dv}) begin
			res = {DUR_BITS'(r2 - {1'b0, dv}), 1'b1};
		end else begin
			res = {r2[DUR_BITS-1:0], 1'b0};
		end
		return res;
	endfunction

	logic [STEP_BITS-1:0] step_q;
	logic                 en;
	logic [N_STAGES-1:0]  vld_s;
	mjs_side_t            side_s [N_STAGES];

	// Step register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			step_q <= cfg_wdata;
		end
	end

	// The pipeline moves whenever the output stage is empty or being taken.
	assign en            = !vld_s[N_STAGES-1] || samp_out.ready;
	assign samp_in.ready = en;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N_STAGES-2:0], samp_in.valid};
		end
	end

	// Stage 0: elapsed time, axis deltas and duration clean-up.
	logic [STEP_BITS-1:0]      step_v;
	logic [DUR_BITS-1:0]       dur_v;
	logic [INDEX_BITS_MAX-1:0] idx_ext;
	logic [INDEX_BITS-1:0]     idx_v;
	logic [2:0][POS_BITS-1:0]  start_a;
	logic [2:0][POS_BITS-1:0]  end_a;
	mjs_side_t                 side_in;
	logic [T_BITS-1:0]         t_s0;
	logic [STEP_BITS-1:0]      step_s0;

	always_comb begin
		logic signed [POS_BITS:0] d;
		step_v  = (step_q == '0) ? STEP_BITS'(1) : step_q;
		dur_v   = (samp_in.data.duration_us == '0) ? DUR_BITS'(1)
			: samp_in.data.duration_us;
		idx_ext = INDEX_BITS_MAX'(samp_in.data.sample_index);
		idx_v   = idx_ext[INDEX_BITS-1:0];
		start_a = {samp_in.data.start_z, samp_in.data.start_y, samp_in.data.start_x};
		end_a   = {samp_in.data.end_z, samp_in.data.end_y, samp_in.data.end_x};
		side_in = '0;
		side_in.dur = dur_v;
		for (int a = 0; a < 3; a++) begin
			d = $signed({end_a[a][POS_BITS-1], end_a[a]})
				- $signed({start_a[a][POS_BITS-1], start_a[a]});
			side_in.st[a]  = start_a[a];
			side_in.neg[a] = d[POS_BITS];
			side_in.mag[a] = d[POS_BITS] ? POS_BITS'(-d) : d[POS_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s0      <= T_BITS'(idx_v) * T_BITS'(step_v);
			step_s0   <= step_v;
			side_s[0] <= side_in;
		end
	end

	// Stage 1: sample flags and the start of the time-ratio division.
	logic [DUR_BITS-1:0] d1_rem_s [D1_STAGES+1];
	logic [FRAC-1:0]     d1_q_s   [D1_STAGES+1];
	logic [63:0]         t_ext;
	mjs_side_t           side_f;

	always_comb begin
		t_ext         = 64'(t_s0);
		side_f        = side_s[0];
		side_f.ge     = t_ext >= 64'(side_s[0].dur);
		side_f.beyond = t_ext > 64'(side_s[0].dur);
		side_f.last   = !side_f.beyond
			&& ((t_ext + 64'(step_s0)) > 64'(side_s[0].dur));
		side_f.tm     = t_ext[TIME_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1]   <= side_f;
			d1_rem_s[0] <= side_f.ge ? '0 : t_ext[DUR_BITS-1:0];
			d1_q_s[0]   <= '0;
		end
	end

	// Side values shift along the remaining stages.
	for (genvar i = 2; i < N_STAGES; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Time-ratio divider: s = t * 2^30 / duration, two quotient bits a stage.
	for (genvar j = 1; j <= D1_STAGES; j++) begin : g_d1
		logic [DUR_BITS-1:0] r_n;
		logic [FRAC-1:0]     q_n;
		logic [DUR_BITS:0]   st_n;
		always_comb begin
			r_n  = d1_rem_s[j-1];
			q_n  = d1_q_s[j-1];
			st_n = '0;
			for (int b = 0; b < DSTEP; b++) begin
				st_n = div_step(r_n, 1'b0, side_s[D1_BASE+j-1].dur);
				r_n  = st_n[DUR_BITS:1];
				q_n  = {q_n[FRAC-2:0], st_n[0]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d1_rem_s[j] <= r_n;
				d1_q_s[j]   <= q_n;
			end
		end
	end

	// Polynomial stages.
	logic [FRAC:0]  s_s17;
	logic [FRAC:0]  s_s18;
	logic [FRAC:0]  s2_s18;
	logic [FRAC:0]  u_s18;
	logic [FRAC:0]  s3_s19;
	logic [33:0]    poly_s19;
	logic [26:0]    uu_s19;
	logic [33:0]    kraw_s20;
	logic [FRAC:0]  kd_s20;
	logic [61:0]    sq_p;
	logic [61:0]    su_p;
	logic [61:0]    s3_p;
	logic [61:0]    uu_p;
	logic [34:0]    poly_c;
	logic [64:0]    k_p;
	logic [50:0]    num_p;

	always_comb begin
		sq_p   = 62'(s_s17) * 62'(s_s17);
		su_p   = 62'(s_s17) * 62'(ONE - s_s17);
		s3_p   = 62'(s2_s18) * 62'(s_s18);
		uu_p   = 62'(u_s18) * 62'(u_s18);
		poly_c = POLY_C0 - 35'(s_s18) * 35'd15 + 35'(s2_s18) * 35'd6;
		k_p    = 65'(s3_s19) * 65'(poly_s19);
		num_p  = 51'(kd_s20) * 51'(US_PER_S);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s17    <= side_s[D1_END].ge ? ONE : {1'b0, d1_q_s[D1_STAGES]};
			s_s18    <= s_s17;
			s2_s18   <= sq_p[60:30];
			u_s18    <= su_p[60:30];
			s3_s19   <= s3_p[60:30];
			poly_s19 <= poly_c[33:0];
			uu_s19   <= uu_p[56:30];
			kraw_s20 <= k_p[63:30];
			kd_s20   <= 31'(uu_s19) * 31'd30;
		end
	end

	// Rate divider: kd * 1e6 * 2^12 / duration, two quotient bits a stage.
	logic [DUR_BITS-1:0] d2_rem_s [D2_STAGES+1];
	logic [NUM_BITS-1:0] d2_q_s   [D2_STAGES+1];
	logic [FRAC:0]       k_s      [D2_STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			d2_rem_s[0] <= '0;
			d2_q_s[0]   <= {1'b0, num_p, {RATE_EXTRA{1'b0}}};
			k_s[0]      <= (kraw_s20 > 34'(ONE)) ? ONE : kraw_s20[FRAC:0];
		end
	end

	for (genvar j = 1; j <= D2_STAGES; j++) begin : g_d2
		logic [DUR_BITS-1:0] r_n;
		logic [NUM_BITS-1:0] q_n;
		logic [DUR_BITS:0]   st_n;
		always_comb begin
			r_n  = d2_rem_s[j-1];
			q_n  = d2_q_s[j-1];
			st_n = '0;
			for (int b = 0; b < DSTEP; b++) begin
				st_n = div_step(r_n, q_n[NUM_BITS-1], side_s[D2_BASE+j-1].dur);
				r_n  = st_n[DUR_BITS:1];
				q_n  = {q_n[NUM_BITS-2:0], st_n[0]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d2_rem_s[j] <= r_n;
				d2_q_s[j]   <= q_n;
				k_s[j]      <= k_s[j-1];
			end
		end
	end

	// Partial products for position and velocity.
	logic [2:0][63:0] pplo_s54;
	logic [2:0][63:0] pphi_s54;
	logic [2:0][62:0] pm_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				pplo_s54[a] <= 64'(side_s[D2_END].mag[a]) * 64'(d2_q_s[D2_STAGES][31:0]);
				pphi_s54[a] <= 64'(side_s[D2_END].mag[a]) * 64'(d2_q_s[D2_STAGES][63:32]);
				pm_s54[a]   <= 63'(side_s[D2_END].mag[a]) * 63'(k_s[D2_STAGES]);
			end
		end
	end

	// Final sums, signs and velocity saturation into the output register.
	logic [2:0][POS_BITS-1:0] pos_n;
	logic [2:0][POS_BITS-1:0] vel_n;
	logic [2:0][POS_BITS-1:0] pos_s55;
	logic [2:0][POS_BITS-1:0] vel_s55;

	always_comb begin
		logic [95:0]       prod;
		logic              sat;
		logic [POS_BITS:0] m;
		logic [POS_BITS+1:0] sum;
		logic [POS_BITS+1:0] st_x;
		for (int a = 0; a < 3; a++) begin
			prod = {pphi_s54[a], 32'h0} + 96'(pplo_s54[a]);
			sat  = |prod[95:73];
			if (side_s[M1].neg[a]) begin
				vel_n[a] = sat ? 32'h8000_0000 : 32'(-{1'b0, prod[72:VEL_SHIFT]});
			end else begin
				vel_n[a] = sat ? 32'h7FFF_FFFF : {1'b0, prod[72:VEL_SHIFT]};
			end
			m    = pm_s54[a][62:30];
			st_x = {{2{side_s[M1].st[a][POS_BITS-1]}}, side_s[M1].st[a]};
			sum  = side_s[M1].neg[a] ? (st_x - {1'b0, m}) : (st_x + {1'b0, m});
			pos_n[a] = sum[POS_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s55 <= pos_n;
			vel_s55 <= vel_n;
		end
	end

	// Output word.
	assign samp_out.valid            = vld_s[M2];
	assign samp_out.data.pos_x       = pos_s55[0];
	assign samp_out.data.pos_y       = pos_s55[1];
	assign samp_out.data.pos_z       = pos_s55[2];
	assign samp_out.data.vel_x       = vel_s55[0];
	assign samp_out.data.vel_y       = vel_s55[1];
	assign samp_out.data.vel_z       = vel_s55[2];
	assign samp_out.data.time_us     = side_s[M2].tm;
	assign samp_out.data.last_sample = side_s[M2].last;
	assign samp_out.data.beyond_end  = side_s[M2].beyond;

	// A sample cannot be both the last one and past the end.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		samp_out.valid |-> !(samp_out.data.last_sample && samp_out.data.beyond_end))
		else $error("last_sample and beyond_end both set");

	// Past the end the blend is flat, so every velocity is zero.
	a_beyond_still: assert property (@(posedge clk) disable iff (!arst_n)
		(samp_out.valid && samp_out.data.beyond_end) |->
		(samp_out.data.vel_x == 0 && samp_out.data.vel_y == 0
		&& samp_out.data.vel_z == 0))
		else $error("non-zero velocity beyond the end of the segment");

	// An accepted word always enters the first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(samp_in.valid && samp_in.ready) |=> vld_s[0])
		else $error("accepted word did not enter the pipeline");

endmodule

// ===== verif/mjs_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels, predicts each sample from the accepted input word and
// compares it with the word that leaves the block.
module mjs_checker #(
	parameter int INDEX_BITS = mjs_pkg::INDEX_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mjs_pkg::STEP_BITS-1:0] cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  mjs_pkg::mjs_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  mjs_pkg::mjs_out_t             out_data,
	output int                            fail_count,
	output int                            pending
);
	import mjs_pkg::*;

	localparam logic [63:0] UNIT = 64'd1 << FRAC;

	logic [STEP_BITS-1:0] step_reg;
	mjs_out_t             sample_q[$];

	assign pending = sample_q.size();

	// Position of one axis: start plus the scaled difference, toward zero.
	function automatic logic [31:0] blend_pos(logic signed [63:0] st,
		logic signed [63:0] d, logic [63:0] k);
		logic [63:0] mag;
		logic [63:0] m;
		begin
			mag = (d < 0) ? 64'(-d) : 64'(d);
			m = (mag * k) >> FRAC;
			blend_pos = (d < 0) ? 32'(st - $signed(m)) : 32'(st + $signed(m));
		end
	endfunction

	// Velocity of one axis, rounded toward zero and saturated.
	function automatic logic [31:0] blend_vel(logic signed [63:0] d, logic [63:0] rate);
		logic [63:0]  mag;
		logic [127:0] prod;
		logic [127:0] v;
		begin
			mag = (d < 0) ? 64'(-d) : 64'(d);
			prod = {64'd0, mag} * {64'd0, rate};
			v = prod >> VEL_SHIFT;
			if (v >= 128'h8000_0000) v = 128'h8000_0000;
			if (d < 0) blend_vel = 32'(-v[32:0]);
			else if (v > 128'h7FFF_FFFF) blend_vel = 32'h7FFF_FFFF;
			else blend_vel = v[31:0];
		end
	endfunction

	// Expected sample for one input word under the current step.
	function automatic mjs_out_t predict_sample(mjs_in_t w, logic [STEP_BITS-1:0] stp);
		logic [63:0]        step, dur, idx, t, last, s, s2, s3, k, u, kd, rate;
		logic signed [63:0] st[3];
		logic signed [63:0] d[3];
		mjs_out_t           r;
		begin
			step = (stp == 0) ? 64'd1 : 64'(stp);
			dur = (w.duration_us == 0) ? 64'd1 : 64'(w.duration_us);
			idx = 64'(w.sample_index) & ((64'd1 << INDEX_BITS) - 1);
			st[0] = 64'(w.start_x); d[0] = 64'(w.end_x) - st[0];
			st[1] = 64'(w.start_y); d[1] = 64'(w.end_y) - st[1];
			st[2] = 64'(w.start_z); d[2] = 64'(w.end_z) - st[2];
			t = idx * step;
			last = dur / step;
			s = (t >= dur) ? UNIT : (t << FRAC) / dur;
			s2 = (s * s) >> FRAC;
			s3 = (s2 * s) >> FRAC;
			k = (s3 * (10 * UNIT - 15 * s + 6 * s2)) >> FRAC;
			if (k > UNIT) k = UNIT;
			u = (s * (UNIT - s)) >> FRAC;
			kd = 30 * ((u * u) >> FRAC);
			rate = ((kd * US_PER_S) << RATE_EXTRA) / dur;
			r.pos_x = blend_pos(st[0], d[0], k);
			r.pos_y = blend_pos(st[1], d[1], k);
			r.pos_z = blend_pos(st[2], d[2], k);
			r.vel_x = blend_vel(d[0], rate);
			r.vel_y = blend_vel(d[1], rate);
			r.vel_z = blend_vel(d[2], rate);
			r.time_us = t[TIME_BITS-1:0];
			r.last_sample = (idx == last);
			r.beyond_end = (t > dur);
			predict_sample = r;
		end
	endfunction

	// Track the step register, queue predictions and compare results.
	always @(posedge clk or negedge arst_n) begin
		mjs_out_t want;
		if (!arst_n) begin
			step_reg <= STEP_RESET;
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready) sample_q.push_back(predict_sample(in_data, step_reg));
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					$display("%0t: unexpected word %h", $time, out_data);
					fail_count <= fail_count + 1;
				end else begin
					want = sample_q.pop_front();
					if (want !== out_data) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, out_data);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_we) step_reg <= cfg_wdata;
		end
	end

endmodule

// ===== verif/tb_min_jerk_segment_sampler_unit.sv =====
`timescale 1ns / 1ps

module tb_min_jerk_segment_sampler_unit;
	import mjs_pkg::*;

	localparam int LATENCY = 56;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [STEP_BITS-1:0] cfg_wdata;
	int                   fail_count;
	int                   pending;
	int                   stall_mode;

	mjs_stream_if #(.payload_t(mjs_in_t))  samp_in ();
	mjs_stream_if #(.payload_t(mjs_out_t)) samp_out ();

	min_jerk_segment_sampler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.samp_in  (samp_in),
		.samp_out (samp_out)
	);

	mjs_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (samp_in.valid),
		.in_ready  (samp_in.ready),
		.in_data   (samp_in.data),
		.out_valid (samp_out.valid),
		.out_ready (samp_out.ready),
		.out_data  (samp_out.data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver stalls follow a slowly changing pattern of their own.
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= int'($urandom_range(0, 3));
		case (stall_mode)
			0: samp_out.ready <= 1'b1;
			1: samp_out.ready <= ($urandom_range(0, 3) != 0);
			2: samp_out.ready <= 1'($urandom_range(0, 1));
			default: samp_out.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Random coordinate: an extreme, a small value or a full-range random word.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: rand_coord = 32'h8000_0000;
			1: rand_coord = 32'h7FFF_FFFF;
			2: rand_coord = 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: rand_coord = $urandom;
		endcase
	endfunction

	// Offer one word and hold it until it is taken.
	task automatic send_word(mjs_in_t w);
		samp_in.data <= w;
		samp_in.valid <= 1'b1;
		@(posedge clk);
		while (!samp_in.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_sample(logic [31:0] sx, logic [31:0] ex, logic [31:0] dur,
		logic [15:0] idx);
		mjs_in_t w;
		w.start_x = sx; w.end_x = ex;
		w.start_y = rand_coord(); w.end_y = rand_coord();
		w.start_z = rand_coord(); w.end_z = rand_coord();
		w.duration_us = dur;
		w.sample_index = idx;
		send_word(w);
	endtask

	task automatic idle_gap();
		samp_in.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// Wait until the pipeline has drained, then write the step register.
	task automatic write_step(logic [STEP_BITS-1:0] v);
		samp_in.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random phase: segments walked at rising indices with random gaps, plus scattered random indices.
	task automatic random_phase(int n_items);
		int          sent;
		int          burst;
		logic [31:0] sx, ex, dur;
		logic [15:0] idx;
		sent = 0;
		burst = $urandom_range(1, 20);
		while (sent < n_items) begin
			sx = rand_coord(); ex = rand_coord();
			dur = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40000);
			idx = 0;
			repeat ($urandom_range(3, 14)) begin
				if ($urandom_range(0, 5) == 0) send_sample(sx, ex, dur, 16'($urandom));
				else send_sample(sx, ex, dur, idx);
				idx = idx + 16'($urandom_range(1, 9));
				sent++;
				if (--burst == 0) begin
					idle_gap();
					burst = $urandom_range(1, 20);
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		stall_mode = 0;
		samp_in.valid = 1'b0;
		samp_in.data = '0;
		samp_out.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words under the reset step: extremes, ends and zero cases.
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd10000, 16'd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd10000, 16'd5);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd10000, 16'd5);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd10000, 16'd10);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd10000, 16'd11);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 16'd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'd0);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 16'hFFFF);
		send_sample(32'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_sample(32'h0001_0000, 32'hFFFF_0000, 32'd999, 16'd0);
		send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'd3000, 16'd1);
		send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'd2500, 16'd2);
		random_phase(150);

		// Largest step; duration below and above it.
		write_step(20'hFFFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd2048);
		send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 16'd0);
		random_phase(100);

		// A zero step counts as one microsecond.
		write_step(20'd0);
		random_phase(120);

		write_step(20'd1);
		send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd65535, 16'hFFFF);
		random_phase(120);

		write_step(20'($urandom_range(2, 5000)));
		random_phase(150);

		samp_in.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mjs_pkg.sv
rtl/mjs_stream_if.sv
rtl/min_jerk_segment_sampler_unit.sv
verif/mjs_checker.sv
verif/tb_min_jerk_segment_sampler_unit.sv
